>>> rtl/rpfa_pkg.sv
`timescale 1ns / 1ps
package rpfa_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int POS_W       = 32;
	localparam int ROT_W       = 16;

	localparam logic CMD_REF = 1'b0;
	localparam logic CMD_ODO = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_X = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Z = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_W = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_X = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = 4'd7;

	localparam logic signed [ROT_W-1:0] Q_ONE = 16'sd16384;

	typedef logic [2:0][POS_W-1:0] vec_t;
	typedef logic [3:0][ROT_W-1:0] quat_t;

	typedef struct packed {
		vec_t  p;
		quat_t q;
	} pose_t;

	typedef struct packed {
		logic  ref_seen;
		logic  odo_seen;
		pose_t ref_pose;
		pose_t odo_pose;
	} latch_t;

	typedef struct packed {
		logic  mode;
		pose_t off;
	} cfg_t;

	localparam pose_t POSE_IDENT = '{p: '0, q: {16'sd0, 16'sd0, 16'sd0, Q_ONE}};

	function automatic logic [POS_W-1:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'h7fffffff;
		end else if (v < -40'sd2147483648) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [ROT_W-1:0] clampq(input logic signed [19:0] v);
		if (v > 20'sd16384) begin
			return 16'h4000;
		end else if (v < -20'sd16384) begin
			return 16'hc000;
		end
		return v[15:0];
	endfunction

	function automatic quat_t clamp_quat(input quat_t q);
		quat_t r;
		for (int i = 0; i < 4; i++) begin
			r[i] = clampq(20'($signed(q[i])));
		end
		return r;
	endfunction

endpackage

>>> rtl/rigid_pose_frame_alignment_core.sv
`timescale 1ns / 1ps
// channel  direction  handshake               word
// in       input      in_valid / in_stall     command, pos_x..z, rot_w..z
// out      output     out_valid / out_stall   out_pos_x..z, out_rot_w..z
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word accepted per cycle while in_stall is low; an odometry word accepted after a reference
// fix reaches out_valid via the queue and 9-stage back pipeline (three 3-stage transform units).
// Reset clears latches, queue and pipeline valid bits; registers return to identity offset.
// out_stall freezes the back pipeline only at out_valid; QUEUE_DEPTH queued words raise in_stall.
module rigid_pose_frame_alignment_core #(
	parameter int QUEUE_DEPTH = rpfa_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [rpfa_pkg::POS_W-1:0]      pos_x,
	input  logic [rpfa_pkg::POS_W-1:0]      pos_y,
	input  logic [rpfa_pkg::POS_W-1:0]      pos_z,
	input  logic [rpfa_pkg::ROT_W-1:0]      rot_w,
	input  logic [rpfa_pkg::ROT_W-1:0]      rot_x,
	input  logic [rpfa_pkg::ROT_W-1:0]      rot_y,
	input  logic [rpfa_pkg::ROT_W-1:0]      rot_z,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rpfa_pkg::POS_W-1:0]      out_pos_x,
	output logic [rpfa_pkg::POS_W-1:0]      out_pos_y,
	output logic [rpfa_pkg::POS_W-1:0]      out_pos_z,
	output logic [rpfa_pkg::ROT_W-1:0]      out_rot_w,
	output logic [rpfa_pkg::ROT_W-1:0]      out_rot_x,
	output logic [rpfa_pkg::ROT_W-1:0]      out_rot_y,
	output logic [rpfa_pkg::ROT_W-1:0]      out_rot_z,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpfa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rpfa_pkg::*;

	cfg_t   cfg_q;
	latch_t latch;
	logic   q_full, q_empty, q_push, q_pop;
	pose_t  q_data, q_head, result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= 1'b0;
			cfg_q.off  <= POSE_IDENT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:  cfg_q.mode     <= cfg_data[0];
				REG_POS_X: cfg_q.off.p[0] <= cfg_data;
				REG_POS_Y: cfg_q.off.p[1] <= cfg_data;
				REG_POS_Z: cfg_q.off.p[2] <= cfg_data;
				REG_ROT_W: cfg_q.off.q[0] <= cfg_data[ROT_W-1:0];
				REG_ROT_X: cfg_q.off.q[1] <= cfg_data[ROT_W-1:0];
				REG_ROT_Y: cfg_q.off.q[2] <= cfg_data[ROT_W-1:0];
				REG_ROT_Z: cfg_q.off.q[3] <= cfg_data[ROT_W-1:0];
				default: ;
			endcase
		end
	end

	rpfa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.rot_w    (rot_w),
		.rot_x    (rot_x),
		.rot_y    (rot_y),
		.rot_z    (rot_z),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_data),
		.latch    (latch)
	);

	rpfa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	rpfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.latch     (latch),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign out_pos_x = result.p[0];
	assign out_pos_y = result.p[1];
	assign out_pos_z = result.p[2];
	assign out_rot_w = result.q[0];
	assign out_rot_x = result.q[1];
	assign out_rot_y = result.q[2];
	assign out_rot_z = result.q[3];

`ifndef NO_ASSERTIONS
	a_no_result_before_ref: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> latch.ref_seen)
		else $error("result without reference fix");

	a_push_fills_queue: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
		else $error("pushed word missing from queue");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("push into full queue");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");
`endif
endmodule

>>> rtl/rpfa_queue.sv
`timescale 1ns / 1ps
module rpfa_queue #(
	parameter int DEPTH = rpfa_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rpfa_pkg::pose_t push_data,
	input  logic            pop,
	output rpfa_pkg::pose_t head,
	output logic            full,
	output logic            empty
);
	import rpfa_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pose_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

>>> rtl/rpfa_front.sv
`timescale 1ns / 1ps
module rpfa_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic [rpfa_pkg::POS_W-1:0]   pos_x,
	input  logic [rpfa_pkg::POS_W-1:0]   pos_y,
	input  logic [rpfa_pkg::POS_W-1:0]   pos_z,
	input  logic [rpfa_pkg::ROT_W-1:0]   rot_w,
	input  logic [rpfa_pkg::ROT_W-1:0]   rot_x,
	input  logic [rpfa_pkg::ROT_W-1:0]   rot_y,
	input  logic [rpfa_pkg::ROT_W-1:0]   rot_z,
	input  logic                         q_full,
	output logic                         q_push,
	output rpfa_pkg::pose_t              q_data,
	output rpfa_pkg::latch_t             latch
);
	import rpfa_pkg::*;

	latch_t latch_q;
	logic   accept;
	pose_t  smp;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign smp.p    = {pos_z, pos_y, pos_x};
	assign smp.q    = clamp_quat({rot_z, rot_y, rot_x, rot_w});
	assign q_data   = smp;
	assign q_push   = accept && (command == CMD_ODO) && latch_q.ref_seen;
	assign latch    = latch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q.ref_seen <= 1'b0;
			latch_q.odo_seen <= 1'b0;
			latch_q.ref_pose <= POSE_IDENT;
			latch_q.odo_pose <= POSE_IDENT;
		end else if (accept) begin
			if (command == CMD_REF && !latch_q.ref_seen) begin
				latch_q.ref_seen <= 1'b1;
				latch_q.ref_pose <= smp;
			end
			if (command == CMD_ODO && !latch_q.odo_seen) begin
				latch_q.odo_seen <= 1'b1;
				latch_q.odo_pose <= smp;
			end
		end
	end
endmodule

>>> rtl/rpfa_xform.sv
`timescale 1ns / 1ps
module rpfa_xform (
	input  logic            clk,
	input  logic            en,
	input  logic            neg,
	input  rpfa_pkg::pose_t a,
	input  rpfa_pkg::pose_t b,
	output rpfa_pkg::pose_t y
);
	import rpfa_pkg::*;

	logic signed [34:0] t_s1 [3];
	logic signed [34:0] t_nx [3];
	quat_t              aq_s1;
	vec_t               ap_s1, bp_s1;
	quat_t              ham_s1, ham_nx;
	logic signed [49:0] d_s2 [3];
	logic signed [49:0] d_nx [3];
	vec_t               ap_s2, bp_s2;
	quat_t              ham_s2;
	pose_t              y_s3;
	vec_t               p_nx;

	always_comb begin
		logic signed [48:0] c;
		logic signed [31:0] h [4];
		logic signed [31:0] r;
		logic signed [31:0] aw, ax, ay, az, bw, bx, by, bz;
		aw = 32'($signed(a.q[0]));
		ax = 32'($signed(a.q[1]));
		ay = 32'($signed(a.q[2]));
		az = 32'($signed(a.q[3]));
		bw = 32'($signed(b.q[0]));
		bx = 32'($signed(b.q[1]));
		by = 32'($signed(b.q[2]));
		bz = 32'($signed(b.q[3]));
		for (int i = 0; i < 3; i++) begin
			c = 49'($signed(a.q[(i + 1) % 3 + 1])) * 49'($signed(b.p[(i + 2) % 3]))
				- 49'($signed(a.q[(i + 2) % 3 + 1])) * 49'($signed(b.p[(i + 1) % 3]));
			c = (c + 49'sd4096) >>> 13;
			t_nx[i] = c[34:0];
		end
		h[0] = 32'(aw * bw) - 32'(ax * bx) - 32'(ay * by) - 32'(az * bz);
		h[1] = 32'(aw * bx) + 32'(ax * bw) + 32'(ay * bz) - 32'(az * by);
		h[2] = 32'(aw * by) - 32'(ax * bz) + 32'(ay * bw) + 32'(az * bx);
		h[3] = 32'(aw * bz) + 32'(ax * by) - 32'(ay * bx) + 32'(az * bw);
		for (int i = 0; i < 4; i++) begin
			r = (h[i] + 32'sd8192) >>> 14;
			ham_nx[i] = clampq(r[19:0]);
		end
		// inverse: pass the conjugate through as the rotation
		if (neg) begin
			ham_nx = a.q;
		end
	end

	always_comb begin
		logic signed [15:0] w;
		w = $signed(aq_s1[0]);
		for (int i = 0; i < 3; i++) begin
			d_nx[i] = 50'(w) * 50'(t_s1[i])
				+ 50'($signed(aq_s1[(i + 1) % 3 + 1])) * 50'(t_s1[(i + 2) % 3])
				- 50'($signed(aq_s1[(i + 2) % 3 + 1])) * 50'(t_s1[(i + 1) % 3]);
		end
	end

	always_comb begin
		logic signed [49:0] rd;
		logic signed [39:0] sum;
		logic signed [31:0] rv;
		for (int i = 0; i < 3; i++) begin
			rd  = (d_s2[i] + 50'sd8192) >>> 14;
			sum = 40'($signed(bp_s2[i])) + rd[39:0];
			rv  = $signed(sat32(sum));
			if (neg) begin
				p_nx[i] = sat32(-40'(rv));
			end else begin
				p_nx[i] = sat32(40'($signed(ap_s2[i])) + 40'(rv));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= t_nx;
			aq_s1  <= a.q;
			ap_s1  <= a.p;
			bp_s1  <= b.p;
			ham_s1 <= ham_nx;
			d_s2   <= d_nx;
			ap_s2  <= ap_s1;
			bp_s2  <= bp_s1;
			ham_s2 <= ham_s1;
			y_s3.p <= p_nx;
			y_s3.q <= ham_s2;
		end
	end

	assign y = y_s3;
endmodule

>>> rtl/rpfa_back.sv
`timescale 1ns / 1ps
module rpfa_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  rpfa_pkg::pose_t  q_head,
	output logic             q_pop,
	input  rpfa_pkg::latch_t latch,
	input  rpfa_pkg::cfg_t   cfg,
	output logic             out_valid,
	input  logic             out_stall,
	output rpfa_pkg::pose_t  result
);
	import rpfa_pkg::*;

	localparam int DEPTH = 9;

	logic  en;
	logic  [DEPTH-1:0] vld_q;
	pose_t smp_q [6];
	pose_t inv_a, oi, off0, off;

	assign en        = !(vld_q[DEPTH-1] && out_stall);
	assign q_pop     = en && !q_empty;
	assign out_valid = vld_q[DEPTH-1];

	always_comb begin
		inv_a.p    = '0;
		inv_a.q[0] = latch.odo_pose.q[0];
		for (int i = 1; i < 4; i++) begin
			inv_a.q[i] = 16'(-$signed(latch.odo_pose.q[i]));
		end
		off.p = cfg.off.p;
		off.q = clamp_quat(cfg.off.q);
		if (!cfg.mode) begin
			off = off0;
		end
	end

	rpfa_xform u_inv (
		.clk (clk),
		.en  (en),
		.neg (1'b1),
		.a   (inv_a),
		.b   (latch.odo_pose),
		.y   (oi)
	);

	rpfa_xform u_off (
		.clk (clk),
		.en  (en),
		.neg (1'b0),
		.a   (latch.ref_pose),
		.b   (oi),
		.y   (off0)
	);

	rpfa_xform u_out (
		.clk (clk),
		.en  (en),
		.neg (1'b0),
		.a   (off),
		.b   (smp_q[5]),
		.y   (result)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			smp_q[0] <= q_head;
			for (int i = 1; i < 6; i++) begin
				smp_q[i] <= smp_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], q_pop};
		end
	end
endmodule
